// File: rtl/core/aofs_pkg.sv
// Package with the sizes, codes, types and helper functions of the arena operand unit.
`timescale 1ns / 1ps

package aofs_pkg;

  // Arena and register file geometry.
  localparam int ARENA_BYTES    = 4096;
  localparam int ADDR_W         = $clog2(ARENA_BYTES);
  localparam int INDEX_MODULUS  = 512;
  localparam int IDX_W          = $clog2(INDEX_MODULUS);
  localparam int INDIRECT_BYTES = 2;
  localparam int WORD_BYTES     = 4;
  localparam int REGISTER_COUNT = 16;
  localparam int REG_IDX_W      = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  // Fixed field widths of the request and response.
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 12;
  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = 5;
  localparam int BYTE_W  = 8;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Argument kinds.
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIRECT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INDIRECT = 2'd3;

  // One response item.
  typedef struct packed {
    logic signed [DATA_W-1:0] operand;
    logic [SIZE_W-1:0]        advance;
    logic                     bad_register;
  } result_t;

  // Reduce a signed address offset to an arena address by wrapping.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic signed [16:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[ADDR_W-1:0];
  endfunction

  // Sign extend a big-endian value of n bytes held in the low bytes.
  function automatic logic [DATA_W-1:0] sext_be(input logic [DATA_W-1:0] v,
                                                input logic [SIZE_W-1:0] n);
    logic [DATA_W-1:0] r;
    unique case (n)
      3'd1:    r = {{24{v[7]}}, v[7:0]};
      3'd2:    r = {{16{v[15]}}, v[15:0]};
      3'd3:    r = {{8{v[23]}}, v[23:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // Turn the 16-bit indirect offset into an arena displacement; unless long
  // mode is set, the offset is cut to a truncating remainder by the modulus.
  function automatic logic [ADDR_W-1:0] indirect_disp(input logic [15:0] raw,
                                                      input logic long_mode);
    logic signed [16:0] s;
    logic signed [16:0] mag;
    logic signed [16:0] r;
    s   = {raw[15], raw};
    mag = raw[15] ? -s : s;
    r   = {{(17 - IDX_W){1'b0}}, mag[IDX_W-1:0]};
    if (raw[15]) begin
      r = -r;
    end
    if (long_mode) begin
      r = s;
    end
    return wrap_addr(r);
  endfunction

endpackage

// File: rtl/core/aofs_if.sv
// Request and response channel interfaces of the arena operand unit.
`timescale 1ns / 1ps

interface aofs_req_if;
  import aofs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         offset;
  logic [KIND_W-1:0]        arg_kind;
  logic [SIZE_W-1:0]        direct_size;
  logic                     long_mode;
  logic [SIZE_W-1:0]        store_size;
  logic signed [DATA_W-1:0] data_value;
  logic [RIDX_W-1:0]        register_index;

  modport source (
    output valid, func, position, offset, arg_kind, direct_size, long_mode,
           store_size, data_value, register_index,
    input  ready
  );

  modport sink (
    input  valid, func, position, offset, arg_kind, direct_size, long_mode,
           store_size, data_value, register_index,
    output ready
  );
endinterface

interface aofs_rsp_if;
  import aofs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] operand;
  logic [SIZE_W-1:0]        advance;
  logic                     bad_register;

  modport source (
    output valid, operand, advance, bad_register,
    input  ready
  );

  modport sink (
    input  valid, operand, advance, bad_register,
    output ready
  );
endinterface

// File: rtl/core/aofs_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module aofs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle; the read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/aofs_alu.sv
// Shared address unit: wrapping arena address adder and byte count compare.
`timescale 1ns / 1ps

module aofs_alu (
  input  logic [aofs_pkg::ADDR_W-1:0] base_i,
  input  logic [aofs_pkg::ADDR_W-1:0] step_i,
  input  logic [aofs_pkg::SIZE_W-1:0] count_i,
  input  logic [aofs_pkg::SIZE_W-1:0] limit_i,
  output logic [aofs_pkg::ADDR_W-1:0] sum_o,
  output logic                        last_o
);
  import aofs_pkg::*;

  // The sum wraps at the arena size, which is a power of two.
  assign sum_o  = base_i + step_i;
  assign last_o = (count_i == limit_i);

endmodule

// File: rtl/core/arena_operand_fetch_store.sv
// Top level of the arena operand unit: sequencer, register file and arena.
`timescale 1ns / 1ps

// Operand unit of a virtual machine with a circular byte arena.
// A request on req_i either stores a value big-endian into the arena, loads
// one register, fetches one instruction argument (register, direct or
// indirect) or does nothing. Every request gives exactly one response on rsp_o.
// Requests are taken one at a time; ready is high only while the sequencer
// is idle. All arena bytes go through one single-port RAM, one byte a cycle,
// and every request address is formed by one shared wrapping adder. An
// indirect argument reads two offset bytes, then four data bytes.
// The next request is taken in the cycle the previous response first shows.
// A finished response sits in the output register until rsp_o.ready; the
// next request is taken meanwhile, but its response waits for the slot.
// After reset the arena is cleared by a pass over all 4096 bytes, one byte a
// cycle, during which no request is taken; the register file clears at once.
module arena_operand_fetch_store (
  input  logic clk_i,
  input  logic rst_ni,
  aofs_req_if.sink   req_i,
  aofs_rsp_if.source rsp_o
);
  import aofs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_BASE   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_IND    = 3'd4;
  localparam logic [2:0] S_STORE  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    off_q, off_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic                long_q, long_d;
  logic [DATA_W-1:0]   sh_q, sh_d;
  logic [SIZE_W-1:0]   cnt_q, cnt_d;
  logic [SIZE_W-1:0]   len_q, len_d;
  logic                pend_q, pend_d;
  logic                ind_ph_q, ind_ph_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  result_t             res_q, res_d;
  logic                rsp_valid_q, rsp_valid_d;
  result_t             rsp_q, rsp_d;
  logic [DATA_W-1:0]   regfile_q [REGISTER_COUNT];

  logic                req_fire;
  logic [SIZE_W-1:0]   dsize_c;
  logic [SIZE_W-1:0]   ssize_c;
  logic [BYTE_W-1:0]   rindex_w;
  logic                rindex_ok;
  logic [BYTE_W-1:0]   rindex_m1;
  logic                reg_we;
  logic [BYTE_W-1:0]   reg_id;
  logic                reg_id_ok;
  logic [BYTE_W-1:0]   reg_id_m1;

  logic [ADDR_W-1:0]   alu_base;
  logic [ADDR_W-1:0]   alu_step;
  logic [ADDR_W-1:0]   alu_sum;
  logic                alu_last;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Request size clamps and the load register index check.
  always_comb begin
    dsize_c = req_i.direct_size;
    if (req_i.direct_size < 3'd2) begin
      dsize_c = 3'd2;
    end else if (req_i.direct_size > 3'd4) begin
      dsize_c = 3'd4;
    end
    ssize_c = (req_i.store_size > 3'd4) ? 3'd4 : req_i.store_size;
  end

  assign rindex_w  = BYTE_W'(req_i.register_index);
  assign rindex_ok = (rindex_w >= 8'd1) && (rindex_w <= BYTE_W'(REGISTER_COUNT));
  assign rindex_m1 = rindex_w - 8'd1;
  assign reg_we    = req_fire && (req_i.func == FUNC_LOAD) && rindex_ok;

  // Register argument: the byte just read names the register.
  assign reg_id    = ram_rdata;
  assign reg_id_ok = (reg_id >= 8'd1) && (reg_id <= BYTE_W'(REGISTER_COUNT));
  assign reg_id_m1 = reg_id - 8'd1;

  // Shared address unit.
  aofs_alu u_alu (
    .base_i  (alu_base),
    .step_i  (alu_step),
    .count_i (cnt_q),
    .limit_i (len_q),
    .sum_o   (alu_sum),
    .last_o  (alu_last)
  );

  // Arena storage.
  aofs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ARENA_BYTES)
  ) u_arena (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    off_d       = off_q;
    kind_d      = kind_q;
    long_d      = long_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    pend_d      = pend_q;
    ind_ph_d    = ind_ph_q;
    base_d      = base_q;
    acc_d       = acc_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    alu_base    = base_q;
    alu_step    = ADDR_W'(cnt_q);
    ram_we      = 1'b0;
    ram_addr    = alu_sum;
    ram_wdata   = sh_q[DATA_W-1 -: BYTE_W];

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(ARENA_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          pos_d    = req_i.position;
          off_d    = req_i.offset;
          kind_d   = req_i.arg_kind;
          long_d   = req_i.long_mode;
          cnt_d    = '0;
          pend_d   = 1'b0;
          ind_ph_d = 1'b0;
          acc_d    = '0;
          res_d    = '0;
          state_d  = S_RESULT;
          unique case (ssize_c)
            3'd1:    sh_d = req_i.data_value << 24;
            3'd2:    sh_d = req_i.data_value << 16;
            3'd3:    sh_d = req_i.data_value << 8;
            default: sh_d = req_i.data_value;
          endcase
          if (req_i.func == FUNC_STORE && ssize_c != 3'd0) begin
            len_d   = ssize_c - 3'd1;
            state_d = S_STORE;
          end else if (req_i.func == FUNC_FETCH && req_i.arg_kind != KIND_NONE) begin
            unique case (req_i.arg_kind)
              KIND_REGISTER: len_d = 3'd1;
              KIND_DIRECT:   len_d = dsize_c;
              default:       len_d = SIZE_W'(INDIRECT_BYTES);
            endcase
            state_d = S_BASE;
          end
        end
      end
      S_BASE: begin
        alu_base = wrap_addr(17'(pos_q));
        alu_step = wrap_addr(17'(off_q));
        base_d   = alu_sum;
        state_d  = S_READ;
      end
      S_READ: begin
        // Issue one byte address a cycle; its data comes back in the next cycle.
        if (!alu_last) begin
          cnt_d  = cnt_q + 3'd1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          acc_d = {acc_q[DATA_W-BYTE_W-1:0], ram_rdata};
        end
        if (alu_last && pend_q) begin
          state_d = S_RESULT;
          priority if (kind_q == KIND_REGISTER) begin
            res_d.advance = 3'd1;
            if (reg_id_ok) begin
              res_d.operand = regfile_q[reg_id_m1[REG_IDX_W-1:0]];
            end else begin
              res_d.bad_register = 1'b1;
            end
          end else if (kind_q == KIND_DIRECT) begin
            res_d.operand = sext_be(acc_d, len_q);
            res_d.advance = len_q;
          end else if (!ind_ph_q) begin
            res_d.advance = SIZE_W'(INDIRECT_BYTES);
            state_d       = S_IND;
          end else begin
            res_d.operand = acc_d;
          end
        end
      end
      S_IND: begin
        alu_base = wrap_addr(17'(pos_q));
        alu_step = indirect_disp(acc_q[15:0], long_q);
        base_d   = alu_sum;
        cnt_d    = '0;
        pend_d   = 1'b0;
        acc_d    = '0;
        len_d    = SIZE_W'(WORD_BYTES);
        ind_ph_d = 1'b1;
        state_d  = S_READ;
      end
      S_STORE: begin
        // Most significant byte first, at rising addresses.
        alu_base = wrap_addr(17'(pos_q));
        ram_we   = 1'b1;
        sh_d     = sh_q << BYTE_W;
        cnt_d    = cnt_q + 3'd1;
        if (alu_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      pend_q      <= 1'b0;
      ind_ph_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      ind_ph_q    <= ind_ph_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    off_q  <= off_d;
    kind_q <= kind_d;
    long_q <= long_d;
    sh_q   <= sh_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    rsp_q  <= rsp_d;
  end

  // Register file, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regfile_q[i] <= '0;
      end
    end else if (reg_we) begin
      regfile_q[rindex_m1[REG_IDX_W-1:0]] <= req_i.data_value;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.operand      = rsp_q.operand;
  assign rsp_o.advance      = rsp_q.advance;
  assign rsp_o.bad_register = rsp_q.bad_register;

  // No request is taken while the arena is being cleared.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request taken during arena clear");

  // An accepted request always starts work away from idle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a request");

  // A bad register response carries a zero operand and one byte of advance.
  a_bad_reg_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bad_register) |->
      (rsp_o.advance == 3'd1 && rsp_o.operand == '0))
    else $error("malformed bad register response");

  // Read data is only captured after at least one address was issued.
  a_pend_has_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && pend_q) |-> (cnt_q != '0))
    else $error("read capture without an issued address");

endmodule
